[hw/rtl/line_rasterizer_dotted_top_assert.svh]
// assertion macros for the line rasterizer
`ifndef LINE_RASTERIZER_DOTTED_TOP_ASSERT_SVH
`define LINE_RASTERIZER_DOTTED_TOP_ASSERT_SVH

// same-cycle implication
`define LRD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lrd_pkg.sv]
`timescale 1ns / 1ps

package lrd_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int TERM_BITS  = COORD_BITS + 4;
   localparam int COLOR_BITS = 4;

   // opcodes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic        [COORD_BITS-1:0] mag_type;
   typedef logic signed [TERM_BITS-1:0]  term_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      logic      opcode;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type color;
      logic      dotted;
   } lrd_item_type;

   typedef struct packed {
      coord_type cur_x;
      coord_type cur_y;
      coord_type major_end;
      term_type  decision_term;
      mag_type   abs_dx;
      mag_type   abs_dy;
      logic      x_major;
      logic      minor_up;
      logic      dot_mode;
      logic      odd_pixel;
      color_type line_color;
      logic      active;
   } lrd_state_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      plot;
      logic      last;
      logic      busy_res;
   } lrd_pixel_type;

endpackage

[hw/rtl/line_rasterizer_dotted_top.sv]
`timescale 1ns / 1ps

// Bresenham line rasterizer, one pixel word out for every request word in.
// A start word (opcode 0) loads both endpoints, the color and the dotted
// flag, picks the major axis (x when |dy| <= |dx|), begins at the endpoint
// lower on that axis and returns that first pixel; every advance word
// (opcode 1) steps one pixel and returns it, with last set on the final
// pixel of the line, after which the block is idle. An advance while idle
// returns an all-zero word with busy_res clear. In dotted mode only the
// even-numbered pixels of a line carry plot = 1. Throughput is one word per
// clock while rsp_stall is low: each step is a few 12 to 16 bit adds and
// compares between the request register and the response register, which
// holds the result of each step. A start while a line is in progress drops
// the old line. rsp_stall reaches req_stall in the same cycle only when both
// registers are full.
`include "line_rasterizer_dotted_top_assert.svh"

module line_rasterizer_dotted_top import lrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   // request channel
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_opcode,
   input  coord_type req_x_start,
   input  coord_type req_y_start,
   input  coord_type req_x_end,
   input  coord_type req_y_end,
   input  color_type req_color,
   input  logic      req_dotted,
   // response channel
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output coord_type rsp_pixel_x,
   output coord_type rsp_pixel_y,
   output color_type rsp_pixel_color,
   output logic      rsp_plot,
   output logic      rsp_last,
   output logic      rsp_busy_res
);

   // request register
   lrd_item_type  item_ff;
   logic          item_valid_ff;
   logic          item_valid_in;
   // line state
   lrd_state_type state_ff;
   lrd_state_type state_in;
   // response register
   lrd_pixel_type pixel_ff;
   lrd_pixel_type pixel_in;
   logic          out_valid_ff;
   logic          out_valid_in;

   logic          req_take;
   logic          step_fire;

   // a step moves the held request word into the response register
   assign step_fire = item_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !step_fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (step_fire) begin
         item_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   lrd_pixel_type step_pixel;
   lrd_state_type step_state;

   lrd_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .state_next (step_state),
      .pixel      (step_pixel)
   );

   // state only advances when the step result is taken into the output stage
   assign state_in = step_fire ? step_state : state_ff;
   assign pixel_in = step_fire ? step_pixel : pixel_ff;

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.opcode  <= req_opcode;
         item_ff.x_start <= req_x_start;
         item_ff.y_start <= req_y_start;
         item_ff.x_end   <= req_x_end;
         item_ff.y_end   <= req_y_end;
         item_ff.color   <= req_color;
         item_ff.dotted  <= req_dotted;
      end
      pixel_ff <= pixel_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = pixel_ff.pixel_x;
   assign rsp_pixel_y     = pixel_ff.pixel_y;
   assign rsp_pixel_color = pixel_ff.pixel_color;
   assign rsp_plot        = pixel_ff.plot;
   assign rsp_last        = pixel_ff.last;
   assign rsp_busy_res    = pixel_ff.busy_res;

   // an idle advance word carries nothing to draw
   `LRD_ASSERT_SAME(a_idle_word_blank, clock, reset, rsp_valid && !rsp_busy_res, !rsp_plot && !rsp_last && rsp_pixel_color == '0, "idle response word not blank")
   // the last pixel of a line leaves the block idle
   `LRD_ASSERT_NEXT(a_last_goes_idle, clock, reset, step_fire && step_pixel.last, !state_ff.active, "line still active after last pixel")
   // request stall only while a word is held and cannot move on
   `LRD_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, item_valid_ff && out_valid_ff && rsp_stall, "request stalled without cause")
   // a step always leaves a word in the response register
   `LRD_ASSERT_NEXT(a_step_lands, clock, reset, step_fire, rsp_valid && rsp_busy_res == $past(step_pixel.busy_res), "step result lost")

endmodule

[hw/rtl/lrd_step.sv]
`timescale 1ns / 1ps

// one rasterizer step: current state and one word in, next state and pixel out
module lrd_step import lrd_pkg::*; (
   input  lrd_item_type  item,
   input  lrd_state_type state,
   output lrd_state_type state_next,
   output lrd_pixel_type pixel
);

   localparam coord_type ONE = COORD_BITS'(1);

   diff_type      dx;
   diff_type      dy;
   mag_type       adx;
   mag_type       ady;
   logic          xmaj;
   term_type      two_adx;
   term_type      two_ady;
   term_type      st_two_adx;
   term_type      st_two_ady;
   coord_type     minor_x;
   coord_type     minor_y;
   logic          is_last;
   lrd_state_type ns;

   always_comb begin
      // start: endpoint differences and magnitudes
      dx   = DIFF_BITS'(item.x_end) - DIFF_BITS'(item.x_start);
      dy   = DIFF_BITS'(item.y_end) - DIFF_BITS'(item.y_start);
      adx  = dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      ady  = dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      xmaj = (ady <= adx);
      two_adx = signed'(TERM_BITS'({adx, 1'b0}));
      two_ady = signed'(TERM_BITS'({ady, 1'b0}));

      // advance: increments from the stored magnitudes
      st_two_adx = signed'(TERM_BITS'({state.abs_dx, 1'b0}));
      st_two_ady = signed'(TERM_BITS'({state.abs_dy, 1'b0}));
      minor_x = state.minor_up ? state.cur_x + ONE : state.cur_x - ONE;
      minor_y = state.minor_up ? state.cur_y + ONE : state.cur_y - ONE;

      ns = state;
      if (item.opcode == OP_START) begin
         ns.abs_dx     = adx;
         ns.abs_dy     = ady;
         ns.minor_up   = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
         ns.line_color = item.color;
         ns.dot_mode   = item.dotted;
         ns.odd_pixel  = 1'b0;
         ns.active     = 1'b1;
         ns.x_major    = xmaj;
         if (xmaj) begin
            ns.decision_term = two_ady - signed'(TERM_BITS'(adx));
            if (!dx[DIFF_BITS-1]) begin
               ns.cur_x = item.x_start; ns.cur_y = item.y_start; ns.major_end = item.x_end;
            end else begin
               ns.cur_x = item.x_end; ns.cur_y = item.y_end; ns.major_end = item.x_start;
            end
         end else begin
            ns.decision_term = two_adx - signed'(TERM_BITS'(ady));
            if (!dy[DIFF_BITS-1]) begin
               ns.cur_x = item.x_start; ns.cur_y = item.y_start; ns.major_end = item.y_end;
            end else begin
               ns.cur_x = item.x_end; ns.cur_y = item.y_end; ns.major_end = item.y_start;
            end
         end
      end else if (state.active) begin
         if (state.x_major) begin
            ns.cur_x = state.cur_x + ONE;
            if (state.decision_term < 0) begin
               ns.decision_term = state.decision_term + st_two_ady;
            end else begin
               ns.cur_y = minor_y;
               ns.decision_term = state.decision_term + st_two_ady - st_two_adx;
            end
         end else begin
            ns.cur_y = state.cur_y + ONE;
            if (state.decision_term <= 0) begin
               ns.decision_term = state.decision_term + st_two_adx;
            end else begin
               ns.cur_x = minor_x;
               ns.decision_term = state.decision_term + st_two_adx - st_two_ady;
            end
         end
      end

      is_last = ns.x_major ? (ns.cur_x >= ns.major_end) : (ns.cur_y >= ns.major_end);

      // emit, unless this is an advance with no line in progress
      if (item.opcode == OP_START || state.active) begin
         pixel.pixel_x     = ns.cur_x;
         pixel.pixel_y     = ns.cur_y;
         pixel.pixel_color = ns.line_color;
         pixel.plot        = !ns.dot_mode || !ns.odd_pixel;
         pixel.last        = is_last;
         pixel.busy_res    = 1'b1;
         ns.odd_pixel      = !ns.odd_pixel;
         ns.active         = !is_last;
      end else begin
         pixel = '0;
      end

      state_next = ns;
   end

endmodule

[sim/line_rasterizer_dotted_checker.sv]
`timescale 1ns / 1ps

module line_rasterizer_dotted_checker import lrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_stall,
   input  logic      req_opcode,
   input  coord_type req_x_start,
   input  coord_type req_y_start,
   input  coord_type req_x_end,
   input  coord_type req_y_end,
   input  color_type req_color,
   input  logic      req_dotted,
   input  logic      rsp_valid,
   input  logic      rsp_stall,
   input  coord_type rsp_pixel_x,
   input  coord_type rsp_pixel_y,
   input  color_type rsp_pixel_color,
   input  logic      rsp_plot,
   input  logic      rsp_last,
   input  logic      rsp_busy_res,
   output int        fail_count,
   output int        pixels_pending,
   output int        pixels_checked,
   output int        lines_started,
   output int        line_ends,
   output int        idle_steps
);

   localparam int MAX_REPORTS = 100;

   // traced line state
   coord_type pos_x;
   coord_type pos_y;
   coord_type axis_end;
   term_type  err_term;
   mag_type   span_x;
   mag_type   span_y;
   logic      along_x;
   logic      minor_inc;
   logic      dots_on;
   logic      odd_next;
   logic      in_line;
   color_type hue;

   lrd_pixel_type expected_pixels[$];
   lrd_pixel_type want;
   lrd_pixel_type next_pixel;

   function automatic lrd_pixel_type trace_pixel(input logic op,
                                                 input coord_type x1, y1, x2, y2,
                                                 input color_type hue_in,
                                                 input logic dot_in);
      int            dx;
      int            dy;
      logic          at_end;
      lrd_pixel_type px;
      px = '0;
      if (op == OP_START) begin
         dx        = int'(x2) - int'(x1);
         dy        = int'(y2) - int'(y1);
         span_x    = mag_type'((dx < 0) ? -dx : dx);
         span_y    = mag_type'((dy < 0) ? -dy : dy);
         minor_inc = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
         hue       = hue_in;
         dots_on   = dot_in;
         odd_next  = 1'b0;
         in_line   = 1'b1;
         along_x   = (span_y <= span_x);
         if (along_x) begin
            err_term = term_type'(2 * int'(span_y) - int'(span_x));
            if (dx >= 0) begin
               pos_x = x1; pos_y = y1; axis_end = x2;
            end else begin
               pos_x = x2; pos_y = y2; axis_end = x1;
            end
         end else begin
            err_term = term_type'(2 * int'(span_x) - int'(span_y));
            if (dy >= 0) begin
               pos_x = x1; pos_y = y1; axis_end = y2;
            end else begin
               pos_x = x2; pos_y = y2; axis_end = y1;
            end
         end
      end else if (in_line) begin
         if (along_x) begin
            pos_x = coord_type'(int'(pos_x) + 1);
            if (err_term < 0) begin
               err_term = term_type'(int'(err_term) + 2 * int'(span_y));
            end else begin
               pos_y    = coord_type'(int'(pos_y) + (minor_inc ? 1 : -1));
               err_term = term_type'(int'(err_term) + 2 * (int'(span_y) - int'(span_x)));
            end
         end else begin
            pos_y = coord_type'(int'(pos_y) + 1);
            if (err_term <= 0) begin
               err_term = term_type'(int'(err_term) + 2 * int'(span_x));
            end else begin
               pos_x    = coord_type'(int'(pos_x) + (minor_inc ? 1 : -1));
               err_term = term_type'(int'(err_term) + 2 * (int'(span_x) - int'(span_y)));
            end
         end
      end
      // an advance while idle leaves the word all zero
      if (in_line) begin
         at_end         = along_x ? (pos_x >= axis_end) : (pos_y >= axis_end);
         px.pixel_x     = pos_x;
         px.pixel_y     = pos_y;
         px.pixel_color = hue;
         px.plot        = !dots_on || !odd_next;
         px.last        = at_end;
         px.busy_res    = 1'b1;
         odd_next       = !odd_next;
         if (at_end) in_line = 1'b0;
      end
      return px;
   endfunction

   function automatic void compare_field(input string name,
                                         input logic signed [31:0] expected_val,
                                         input logic signed [31:0] actual_val);
      if (actual_val !== expected_val) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pos_x     = '0;
         pos_y     = '0;
         axis_end  = '0;
         err_term  = '0;
         span_x    = '0;
         span_y    = '0;
         along_x   = 1'b0;
         minor_inc = 1'b0;
         dots_on   = 1'b0;
         odd_next  = 1'b0;
         in_line   = 1'b0;
         hue       = '0;
         expected_pixels.delete();
      end else begin
         // check the response first so a word in flight never matches a fresh request
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $error("pixel word with no request waiting: x %0d y %0d",
                         rsp_pixel_x, rsp_pixel_y);
            end else begin
               want = expected_pixels.pop_front();
               compare_field("pixel_x", want.pixel_x, rsp_pixel_x);
               compare_field("pixel_y", want.pixel_y, rsp_pixel_y);
               compare_field("pixel_color", {1'b0, want.pixel_color},
                             {1'b0, rsp_pixel_color});
               compare_field("plot", {1'b0, want.plot}, {1'b0, rsp_plot});
               compare_field("last", {1'b0, want.last}, {1'b0, rsp_last});
               compare_field("busy_res", {1'b0, want.busy_res}, {1'b0, rsp_busy_res});
               pixels_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            next_pixel = trace_pixel(req_opcode, req_x_start, req_y_start, req_x_end,
                                     req_y_end, req_color, req_dotted);
            expected_pixels.push_back(next_pixel);
            if (req_opcode == OP_START) lines_started++;
            if (!next_pixel.busy_res) idle_steps++;
            if (next_pixel.last) line_ends++;
         end
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

[sim/line_rasterizer_dotted_top_tb.sv]
`timescale 1ns / 1ps

module line_rasterizer_dotted_top_tb import lrd_pkg::*; ();

   // run shape
   localparam int ITEM_TARGET    = 1950;
   localparam int HOLD_CYCLES    = 150;   // long receiver hold-off under pressure
   localparam int DRAIN_CYCLES   = 8;     // extra clocks after the last expected pixel word
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int IDLE_PERCENT   = 15;
   localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));

   logic      clock = 1'b0;
   logic      reset = 1'b1;

   // request channel, all known from time zero
   logic      req_valid   = 1'b0;
   logic      req_stall;
   logic      req_opcode  = OP_START;
   coord_type req_x_start = '0;
   coord_type req_y_start = '0;
   coord_type req_x_end   = '0;
   coord_type req_y_end   = '0;
   color_type req_color   = '0;
   logic      req_dotted  = 1'b0;

   // response channel
   logic      rsp_valid;
   logic      rsp_stall   = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   color_type rsp_pixel_color;
   logic      rsp_plot;
   logic      rsp_last;
   logic      rsp_busy_res;

   // figures handed back by the checker
   int        fail_count;
   int        pixels_pending;
   int        pixels_checked;
   int        lines_started;
   int        line_ends;
   int        idle_steps;

   // traffic shaping
   logic      calm          = 1'b0;  // no idling on either side
   logic      pressure      = 1'b0;  // sender streams, receiver holds off once
   logic      pressure_seen = 1'b0;
   int        hold_left     = 0;
   int        words_sent    = 0;
   int        stuck_cycles  = 0;

   always #5 clock = ~clock;

   line_rasterizer_dotted_top u_dut (.*);

   line_rasterizer_dotted_checker u_checker (.*);

   // receiver: random stalls, a quiet stretch, and one long hold when pressure begins
   always @(negedge clock) begin
      pressure_seen <= pressure;
      if (pressure && !pressure_seen) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // watchdog: ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("line_rasterizer_dotted_top_tb failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic int random_coord();
      return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // offer one request word at a falling edge and hold it until it is taken
   task automatic send_word(input logic op, input coord_type xs, ys, xe, ye,
                            input color_type hue, input logic dot);
      // random gaps, never while streaming
      while (!calm && !pressure && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      req_color   <= hue;
      req_dotted  <= dot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic start_line(input int xs, ys, xe, ye, input int hue, input logic dot);
      send_word(OP_START, coord_type'(xs), coord_type'(ys), coord_type'(xe),
                coord_type'(ye), color_type'(hue), dot);
   endtask

   // advance words carry random noise in the unused fields
   task automatic advance_line(input int count);
      repeat (count)
         send_word(OP_ADVANCE, coord_type'($urandom), coord_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom),
                   color_type'($urandom), 1'($urandom_range(1)));
   endtask

   // mostly short whole lines, some cut short or run past the end,
   // a few long ones and a few endpoints anywhere that get abandoned
   task automatic random_line();
      int kind;
      int reach;
      int xs;
      int ys;
      int xe;
      int ye;
      int len;
      int len_y;
      int steps;
      kind = $urandom_range(99);
      xs   = random_coord();
      ys   = random_coord();
      if (kind < 6) begin
         xe = random_coord();
         ye = random_coord();
      end else begin
         reach = (kind < 8) ? 150 : 20;
         xe = clamp_coord(xs + int'($urandom_range(2 * reach)) - reach);
         ye = clamp_coord(ys + int'($urandom_range(2 * reach)) - reach);
      end
      len   = (xe > xs) ? xe - xs : xs - xe;
      len_y = (ye > ys) ? ye - ys : ys - ye;
      if (len_y > len) len = len_y;
      if (kind < 6) begin
         steps = $urandom_range(6);
      end else begin
         case ($urandom_range(9))
            0:       steps = $urandom_range(len);
            1:       steps = len + $urandom_range(1, 3);
            default: steps = len;
         endcase
      end
      start_line(xs, ys, xe, ye, $urandom_range(15), 1'($urandom_range(1)));
      advance_line(steps);
   endtask

   task automatic run_random(input int until_words);
      while (words_sent < until_words) random_line();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: advance with no line in progress
      advance_line(1);
      // single-point line, then an advance after it has ended
      start_line(0, 0, 0, 0, 0, 1'b0);
      advance_line(1);
      // x-major rising, dotted, full color
      start_line(0, 0, 3, 1, 15, 1'b1);
      advance_line(3);
      // x-major drawn from the second endpoint, falling minor axis, run past the end
      start_line(3, -1, 0, 1, 5, 1'b0);
      advance_line(4);
      // y-major drawn from the second endpoint, both deltas negative
      start_line(1, 4, -1, -2, 9, 1'b1);
      advance_line(2);
      // corner to corner, abandoned by the next start
      start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 10, 1'b0);
      advance_line(2);
      // opposite diagonal, equal deltas pick x as major
      start_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 6, 1'b1);
      advance_line(2);
      // vertical line down the left edge
      start_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 3, 1'b0);
      advance_line(1);
      // horizontal line to the right edge, abandoned by the random part
      start_line(7, 7, COORD_MAX, 7, 12, 1'b1);

      // random part with a quiet stretch and a pressure stretch
      run_random(300);
      calm <= 1'b1;
      run_random(550);
      calm <= 1'b0;
      pressure <= 1'b1;
      run_random(620);
      pressure <= 1'b0;
      run_random(ITEM_TARGET);
      req_valid <= 1'b0;

      // let every expected pixel word come back, then a few more clocks
      while (pixels_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d request words: %0d lines started, %0d line ends, %0d idle advances",
               words_sent, lines_started, line_ends, idle_steps);
      $display("checked %0d pixel words, including a %0d cycle receiver hold-off",
               pixels_checked, HOLD_CYCLES);
      if (fail_count == 0)
         $display("line_rasterizer_dotted_top_tb passed");
      else
         $display("line_rasterizer_dotted_top_tb failed");
      $finish;
   end

endmodule
